// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the MessagePack token decoder.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- rtl/mptd_pkg.sv -----
// Types and constants of the MessagePack token decoder.
// Depends on nothing; used by msgpack_token_decoder.
`timescale 1ns / 1ps

package mptd_pkg;

	typedef enum logic [3:0] {
		K_NIL     = 4'd0,
		K_FALSE   = 4'd1,
		K_TRUE    = 4'd2,
		K_INT     = 4'd3,
		K_FLOAT   = 4'd4,
		K_STR     = 4'd5,
		K_BIN     = 4'd6,
		K_ARRAY   = 4'd7,
		K_MAP     = 4'd8,
		K_PAYLOAD = 4'd9,
		K_BADTYPE = 4'd10,
		K_TRUNC   = 4'd11
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_FIELD   = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	localparam logic [7:0] TB_POSFIX_MAX = 8'h7f;
	localparam logic [7:0] TB_NEGFIX_MIN = 8'he0;
	localparam logic [7:0] TB_FIXMAP_MAX = 8'h8f;
	localparam logic [7:0] TB_FIXARR_MAX = 8'h9f;
	localparam logic [7:0] TB_FIXSTR_MAX = 8'hbf;
	localparam logic [7:0] TB_NIL        = 8'hc0;
	localparam logic [7:0] TB_FALSE      = 8'hc2;
	localparam logic [7:0] TB_TRUE       = 8'hc3;
	localparam logic [7:0] TB_BIN8       = 8'hc4;
	localparam logic [7:0] TB_BIN16      = 8'hc5;
	localparam logic [7:0] TB_BIN32      = 8'hc6;
	localparam logic [7:0] TB_FLOAT32    = 8'hca;
	localparam logic [7:0] TB_FLOAT64    = 8'hcb;
	localparam logic [7:0] TB_UINT8      = 8'hcc;
	localparam logic [7:0] TB_UINT16     = 8'hcd;
	localparam logic [7:0] TB_UINT32     = 8'hce;
	localparam logic [7:0] TB_UINT64     = 8'hcf;
	localparam logic [7:0] TB_INT8       = 8'hd0;
	localparam logic [7:0] TB_INT16      = 8'hd1;
	localparam logic [7:0] TB_INT32      = 8'hd2;
	localparam logic [7:0] TB_INT64      = 8'hd3;
	localparam logic [7:0] TB_STR8       = 8'hd9;
	localparam logic [7:0] TB_STR16      = 8'hda;
	localparam logic [7:0] TB_STR32      = 8'hdb;
	localparam logic [7:0] TB_ARRAY16    = 8'hdc;
	localparam logic [7:0] TB_ARRAY32    = 8'hdd;
	localparam logic [7:0] TB_MAP16      = 8'hde;
	localparam logic [7:0] TB_MAP32      = 8'hdf;

	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

endpackage

// ----- rtl/msgpack_token_decoder.sv -----
// MessagePack token decoder: one stream byte per transaction, at most one result each.
// Depends on mptd_pkg and assert_macros.svh.
//
// Channel   Dir  Fields (tdata / tuser / tlast)
// s_axis    in   data_byte / - / end_of_data
// m_axis    out  value / kind / payload_last
//
// A byte is registered on acceptance, decoded combinationally against the token state
// and its result, if any, lands in the output register when the input stage advances.
// One byte is taken in every cycle while the output register drains or is free.
// Reset clears the token state and both valid flags; the block then expects a header.
// A stalled output holds its result, and once the input stage is full s_axis_tready falls.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module msgpack_token_decoder
	import mptd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] value
	output logic [3:0]  m_axis_tuser,   // [3:0] kind
	output logic        m_axis_tlast
);

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        eod_s1;
	logic        adv;

	phase_t      phase_q, ph_d;
	kind_t       pend_q, pk_d;
	logic [3:0]  fleft_q, fl_d;
	logic [1:0]  wcode_q, wc_d;
	logic        sgn_q, sg_d;
	logic        single_q, sf_d;
	logic [63:0] asm_q, asm_d;
	logic [31:0] pleft_q, pl_d;

	logic        res_vld;
	kind_t       res_kind;
	logic [63:0] res_val;
	logic        res_last;

	logic        out_vld_q;
	kind_t       out_kind_q;
	logic [63:0] out_val_q;
	logic        out_last_q;

	function automatic logic [4:0] lead_zeros23(input logic [22:0] m);
		logic [4:0] n;
		n = 5'd23;
		for (int i = 0; i < 23; i++) begin
			if (m[i]) begin
				n = 5'(22 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [63:0] widen_single(input logic [31:0] f);
		logic        s;
		logic [7:0]  e;
		logic [22:0] m;
		logic [4:0]  lz;
		logic [52:0] sh;
		logic [63:0] r;
		s  = f[31];
		e  = f[30:23];
		m  = f[22:0];
		lz = lead_zeros23(m);
		sh = {1'b0, m, 29'd0} << (lz + 5'd1);
		if (e == 8'hff) begin
			r = {s, 11'h7ff, (m != 23'd0), m[21:0], 29'd0};
		end else if (e == 8'd0) begin
			if (m == 23'd0) begin
				r = {s, 63'd0};
			end else begin
				r = {s, 11'(11'd896 - 11'(lz)), sh[51:0]};
			end
		end else begin
			r = {s, 11'(11'(e) + 11'd896), m, 29'd0};
		end
		return r;
	endfunction

	assign adv           = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eod_s1  <= s_axis_tlast;
		end
	end

	always_comb begin
		logic [63:0] nasm;
		logic [3:0]  nleft;
		logic        st_go;
		kind_t       st_kind;
		logic [1:0]  st_code;
		logic        st_sgn;
		logic        st_single;
		logic        lh_go;
		kind_t       lh_kind;
		logic [31:0] lh_len;
		logic        trunc;

		ph_d     = phase_q;
		pk_d     = pend_q;
		fl_d     = fleft_q;
		wc_d     = wcode_q;
		sg_d     = sgn_q;
		sf_d     = single_q;
		asm_d    = asm_q;
		pl_d     = pleft_q;
		res_vld  = 1'b0;
		res_kind = K_NIL;
		res_val  = 64'd0;
		res_last = 1'b0;
		nasm      = {asm_q[55:0], byte_s1};
		nleft     = fleft_q - 4'd1;
		st_go     = 1'b0;
		st_kind   = K_INT;
		st_code   = 2'd0;
		st_sgn    = 1'b0;
		st_single = 1'b0;
		lh_go     = 1'b0;
		lh_kind   = K_STR;
		lh_len    = 32'd0;
		trunc     = 1'b0;

		unique case (phase_q)
			PH_PAYLOAD: begin
				if (eod_s1 && pleft_q != 32'd1) begin
					trunc = 1'b1;
				end else begin
					res_vld  = 1'b1;
					res_kind = K_PAYLOAD;
					res_val  = {56'd0, byte_s1};
					res_last = (pleft_q == 32'd1);
					pl_d     = pleft_q - 32'd1;
					if (pleft_q == 32'd1) begin
						ph_d = PH_HEADER;
						pl_d = 32'd0;
					end
				end
			end
			PH_FIELD: begin
				asm_d = nasm;
				fl_d  = nleft;
				if (nleft != 4'd0) begin
					trunc = eod_s1;
				end else begin
					ph_d = PH_HEADER;
					unique case (pend_q)
						K_INT: begin
							res_vld  = 1'b1;
							res_kind = K_INT;
							unique case (wcode_q)
								WC_8:   res_val = {{56{sgn_q & nasm[7]}}, nasm[7:0]};
								WC_16:  res_val = {{48{sgn_q & nasm[15]}}, nasm[15:0]};
								WC_32:  res_val = {{32{sgn_q & nasm[31]}}, nasm[31:0]};
								default: res_val = nasm;
							endcase
						end
						K_FLOAT: begin
							res_vld  = 1'b1;
							res_kind = K_FLOAT;
							res_val  = single_q ? widen_single(nasm[31:0]) : nasm;
						end
						K_STR, K_BIN: begin
							lh_go   = 1'b1;
							lh_kind = pend_q;
							lh_len  = nasm[31:0];
						end
						default: begin
							res_vld  = 1'b1;
							res_kind = pend_q;
							res_val  = nasm;
						end
					endcase
				end
			end
			default: begin
				ph_d = PH_HEADER;
				if (byte_s1 <= TB_POSFIX_MAX) begin
					res_vld  = 1'b1;
					res_kind = K_INT;
					res_val  = {56'd0, byte_s1};
				end else if (byte_s1 >= TB_NEGFIX_MIN) begin
					res_vld  = 1'b1;
					res_kind = K_INT;
					res_val  = {{56{1'b1}}, byte_s1};
				end else if (byte_s1 <= TB_FIXMAP_MAX) begin
					res_vld  = 1'b1;
					res_kind = K_MAP;
					res_val  = {60'd0, byte_s1[3:0]};
				end else if (byte_s1 <= TB_FIXARR_MAX) begin
					res_vld  = 1'b1;
					res_kind = K_ARRAY;
					res_val  = {60'd0, byte_s1[3:0]};
				end else if (byte_s1 <= TB_FIXSTR_MAX) begin
					lh_go   = 1'b1;
					lh_kind = K_STR;
					lh_len  = {27'd0, byte_s1[4:0]};
				end else begin
					unique case (byte_s1)
						TB_NIL: begin
							res_vld  = 1'b1;
							res_kind = K_NIL;
						end
						TB_FALSE: begin
							res_vld  = 1'b1;
							res_kind = K_FALSE;
						end
						TB_TRUE: begin
							res_vld  = 1'b1;
							res_kind = K_TRUE;
						end
						TB_BIN8, TB_BIN16, TB_BIN32: begin
							st_go   = 1'b1;
							st_kind = K_BIN;
							st_code = byte_s1[1:0];
						end
						TB_FLOAT32: begin
							st_go     = 1'b1;
							st_kind   = K_FLOAT;
							st_code   = WC_32;
							st_single = 1'b1;
						end
						TB_FLOAT64: begin
							st_go   = 1'b1;
							st_kind = K_FLOAT;
							st_code = WC_64;
						end
						TB_UINT8, TB_UINT16, TB_UINT32, TB_UINT64: begin
							st_go   = 1'b1;
							st_kind = K_INT;
							st_code = byte_s1[1:0];
						end
						TB_INT8, TB_INT16, TB_INT32, TB_INT64: begin
							st_go   = 1'b1;
							st_kind = K_INT;
							st_code = byte_s1[1:0];
							st_sgn  = 1'b1;
						end
						TB_STR8, TB_STR16, TB_STR32: begin
							st_go   = 1'b1;
							st_kind = K_STR;
							st_code = byte_s1[1:0] - 2'd1;
						end
						TB_ARRAY16: begin
							st_go   = 1'b1;
							st_kind = K_ARRAY;
							st_code = WC_16;
						end
						TB_ARRAY32: begin
							st_go   = 1'b1;
							st_kind = K_ARRAY;
							st_code = WC_32;
						end
						TB_MAP16: begin
							st_go   = 1'b1;
							st_kind = K_MAP;
							st_code = WC_16;
						end
						TB_MAP32: begin
							st_go   = 1'b1;
							st_kind = K_MAP;
							st_code = WC_32;
						end
						default: begin
							res_vld  = 1'b1;
							res_kind = K_BADTYPE;
							res_val  = {56'd0, byte_s1};
						end
					endcase
				end
			end
		endcase

		if (st_go) begin
			pk_d  = st_kind;
			wc_d  = st_code;
			fl_d  = 4'd1 << st_code;
			sg_d  = st_sgn;
			sf_d  = st_single;
			asm_d = 64'd0;
			ph_d  = PH_FIELD;
			trunc = eod_s1;
		end

		if (lh_go) begin
			if (lh_len != 32'd0 && eod_s1) begin
				trunc = 1'b1;
			end else begin
				res_vld  = 1'b1;
				res_kind = lh_kind;
				res_val  = {32'd0, lh_len};
				pl_d     = lh_len;
				ph_d     = (lh_len != 32'd0) ? PH_PAYLOAD : PH_HEADER;
			end
		end

		if (trunc) begin
			ph_d     = PH_HEADER;
			pl_d     = 32'd0;
			fl_d     = 4'd0;
			res_vld  = 1'b1;
			res_kind = K_TRUNC;
			res_val  = 64'd0;
			res_last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pend_q   <= K_NIL;
			fleft_q  <= 4'd0;
			wcode_q  <= 2'd0;
			sgn_q    <= 1'b0;
			single_q <= 1'b0;
			asm_q    <= 64'd0;
			pleft_q  <= 32'd0;
		end else if (adv) begin
			phase_q  <= ph_d;
			pend_q   <= pk_d;
			fleft_q  <= fl_d;
			wcode_q  <= wc_d;
			sgn_q    <= sg_d;
			single_q <= sf_d;
			asm_q    <= asm_d;
			pleft_q  <= pl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && res_vld) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld) begin
			out_kind_q <= res_kind;
			out_val_q  <= res_val;
			out_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	`ASSERT_NEVER(a_payload_count, clk, arst_n, phase_q == PH_PAYLOAD && pleft_q == 32'd0, "Payload phase with no bytes left.")
	`ASSERT_NEVER(a_field_count, clk, arst_n, phase_q == PH_FIELD && fleft_q == 4'd0, "Field phase with no bytes left.")
	`ASSERT_PROP(a_eod_resync, clk, arst_n, (adv && eod_s1) |=> (phase_q == PH_HEADER), "State not back to header after end of buffer.")
	`ASSERT_PROP(a_last_is_payload, clk, arst_n, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == K_PAYLOAD), "Last flag on a result that is not payload.")
	`ASSERT_PROP(a_no_overwrite, clk, arst_n, (out_vld_q && !m_axis_tready) |-> !adv, "Input stage advanced into a stalled output register.")

endmodule

// ----- tb/msgpack_result_checker.sv -----
// Result checker for the MessagePack token decoder: predicts each decoded token from the
// accepted stream bytes and compares it with the output channel, field by field.
// Depends on mptd_pkg; instantiated by tb_top beside the decoder.
`timescale 1ns / 1ps

module msgpack_result_checker
	import mptd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] out_value,
	input  logic [3:0]  out_kind,
	input  logic        out_last,
	output int          mismatches,
	output int          outstanding,
	output int          checked,
	output logic [11:0] kinds_seen
);

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic        last;
	} token_t;

	phase_t      ph;
	kind_t       pend_kind;
	logic [3:0]  field_left;
	logic [1:0]  width_code;
	logic        field_signed;
	logic        field_single;
	logic [63:0] assembly;
	logic [31:0] payload_left;

	token_t      expected_tokens[$];
	int          mismatch_total;
	int          checked_total;
	logic [11:0] kinds_total;
	token_t      want;
	token_t      seen;
	token_t      predicted;
	bit          produced;

	function automatic token_t make_token(input kind_t k, input logic [63:0] v, input logic l);
		token_t t;
		t.kind = k;
		t.value = v;
		t.last = l;
		return t;
	endfunction

	function automatic logic [63:0] single_to_double(input logic [31:0] f);
		logic [7:0]  e;
		logic [22:0] m;
		logic [63:0] d;
		logic [63:0] frac;
		int          p;
		e = f[30:23];
		m = f[22:0];
		d = '0;
		d[63] = f[31];
		if (e == 8'hff) begin
			d[62:52] = 11'h7ff;
			d[51:29] = m;
			if (m != '0)
				d[51] = 1'b1;
		end else if (e == 8'h00) begin
			if (m != '0) begin
				// A subnormal single becomes a normal double: find its leading one.
				p = 22;
				while (p > 0 && !m[p])
					p--;
				d[62:52] = 11'(p + 874);
				frac = {41'd0, m} << (52 - p);
				d[51:0] = frac[51:0];
			end
		end else begin
			d[62:52] = {3'b000, e} + 11'd896;
			d[51:29] = m;
		end
		return d;
	endfunction

	function automatic token_t truncate_token();
		ph = PH_HEADER;
		payload_left = '0;
		field_left = '0;
		return make_token(K_TRUNC, 64'd0, 1'b0);
	endfunction

	function automatic token_t length_header(input kind_t k, input logic [31:0] len,
		input logic eod);
		if (len != '0 && eod)
			return truncate_token();
		payload_left = len;
		ph = (len != '0) ? PH_PAYLOAD : PH_HEADER;
		return make_token(k, {32'd0, len}, 1'b0);
	endfunction

	function automatic bit start_field(input kind_t k, input logic [1:0] code, input logic sgn,
		input logic single, input logic eod, output token_t r);
		pend_kind = k;
		width_code = code;
		field_left = 4'd1 << code;
		field_signed = sgn;
		field_single = single;
		assembly = '0;
		ph = PH_FIELD;
		r = make_token(K_NIL, 64'd0, 1'b0);
		if (eod) begin
			r = truncate_token();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit decode_step(input logic [7:0] b, input logic eod, output token_t r);
		logic        last;
		logic [63:0] v;
		logic [7:0]  rel;
		int          bits;
		r = make_token(K_NIL, 64'd0, 1'b0);
		case (ph)
		PH_PAYLOAD: begin
			if (eod && payload_left > 32'd1) begin
				r = truncate_token();
				return 1'b1;
			end
			last = (payload_left <= 32'd1);
			if (payload_left > '0)
				payload_left--;
			if (last || eod) begin
				ph = PH_HEADER;
				payload_left = '0;
			end
			r = make_token(K_PAYLOAD, {56'd0, b}, last);
			return 1'b1;
		end
		PH_FIELD: begin
			assembly = {assembly[55:0], b};
			if (field_left > '0)
				field_left--;
			if (field_left > '0) begin
				if (eod) begin
					r = truncate_token();
					return 1'b1;
				end
				return 1'b0;
			end
			ph = PH_HEADER;
			v = assembly;
			bits = 8 << width_code;
			case (pend_kind)
			K_INT: begin
				if (field_signed && bits < 64 && v[bits - 1])
					v |= ~((64'd1 << bits) - 64'd1);
			end
			K_FLOAT: begin
				if (field_single)
					v = single_to_double(v[31:0]);
			end
			K_STR, K_BIN: begin
				r = length_header(pend_kind, v[31:0], eod);
				return 1'b1;
			end
			default: ;
			endcase
			r = make_token(pend_kind, v, 1'b0);
			return 1'b1;
		end
		default: begin
			ph = PH_HEADER;
			if (b <= TB_POSFIX_MAX)
				r = make_token(K_INT, {56'd0, b}, 1'b0);
			else if (b >= TB_NEGFIX_MIN)
				r = make_token(K_INT, {56'hff_ffff_ffff_ffff, b}, 1'b0);
			else if (b <= TB_FIXMAP_MAX)
				r = make_token(K_MAP, {60'd0, b[3:0]}, 1'b0);
			else if (b <= TB_FIXARR_MAX)
				r = make_token(K_ARRAY, {60'd0, b[3:0]}, 1'b0);
			else if (b <= TB_FIXSTR_MAX)
				r = length_header(K_STR, {27'd0, b[4:0]}, eod);
			else begin
				case (b)
				TB_NIL:   r = make_token(K_NIL, 64'd0, 1'b0);
				TB_FALSE: r = make_token(K_FALSE, 64'd0, 1'b0);
				TB_TRUE:  r = make_token(K_TRUE, 64'd0, 1'b0);
				TB_BIN8, TB_BIN16, TB_BIN32: begin
					rel = b - TB_BIN8;
					return start_field(K_BIN, rel[1:0], 1'b0, 1'b0, eod, r);
				end
				TB_FLOAT32:
					return start_field(K_FLOAT, WC_32, 1'b0, 1'b1, eod, r);
				TB_FLOAT64:
					return start_field(K_FLOAT, WC_64, 1'b0, 1'b0, eod, r);
				TB_UINT8, TB_UINT16, TB_UINT32, TB_UINT64: begin
					rel = b - TB_UINT8;
					return start_field(K_INT, rel[1:0], 1'b0, 1'b0, eod, r);
				end
				TB_INT8, TB_INT16, TB_INT32, TB_INT64: begin
					rel = b - TB_INT8;
					return start_field(K_INT, rel[1:0], 1'b1, 1'b0, eod, r);
				end
				TB_STR8, TB_STR16, TB_STR32: begin
					rel = b - TB_STR8;
					return start_field(K_STR, rel[1:0], 1'b0, 1'b0, eod, r);
				end
				TB_ARRAY16: return start_field(K_ARRAY, WC_16, 1'b0, 1'b0, eod, r);
				TB_ARRAY32: return start_field(K_ARRAY, WC_32, 1'b0, 1'b0, eod, r);
				TB_MAP16:   return start_field(K_MAP, WC_16, 1'b0, 1'b0, eod, r);
				TB_MAP32:   return start_field(K_MAP, WC_32, 1'b0, 1'b0, eod, r);
				default:    r = make_token(K_BADTYPE, {56'd0, b}, 1'b0);
				endcase
			end
			return 1'b1;
		end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input token_t exp_tok, input token_t got);
		mismatch_total++;
		if (mismatch_total <= 10)
			$display("Mismatch, %s: expected kind %0d value %h last %b, got kind %0d value %h last %b",
				what, exp_tok.kind, exp_tok.value, exp_tok.last, got.kind, got.value, got.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_HEADER;
			pend_kind = K_NIL;
			field_left = '0;
			width_code = '0;
			field_signed = 1'b0;
			field_single = 1'b0;
			assembly = '0;
			payload_left = '0;
			expected_tokens.delete();
			mismatch_total = 0;
			checked_total = 0;
			kinds_total = '0;
			mismatches <= 0;
			outstanding <= 0;
			checked <= 0;
			kinds_seen <= '0;
		end else begin
			if (out_valid && out_ready) begin
				seen = make_token(kind_t'(out_kind), out_value, out_last);
				checked_total++;
				if (out_kind < 4'd12)
					kinds_total[out_kind] = 1'b1;
				if (expected_tokens.size() == 0) begin
					report_mismatch("no result was due", make_token(K_NIL, 64'd0, 1'b0), seen);
				end else begin
					want = expected_tokens.pop_front();
					if (seen.kind != want.kind || seen.value != want.value
						|| seen.last != want.last)
						report_mismatch("wrong field", want, seen);
				end
			end
			if (in_valid && in_ready) begin
				produced = decode_step(in_byte, in_end, predicted);
				if (produced)
					expected_tokens.push_back(predicted);
			end
			mismatches <= mismatch_total;
			outstanding <= expected_tokens.size();
			checked <= checked_total;
			kinds_seen <= kinds_total;
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the MessagePack token decoder testbench: drives byte streams with random idling
// on both channels, then with none, and gives the verdict from the result checker.
// Depends on mptd_pkg, msgpack_token_decoder and msgpack_result_checker.
`timescale 1ns / 1ps

module tb_top
	import mptd_pkg::*;
();

	localparam int         CYCLE_LIMIT = 200000;
	localparam logic [7:0] TB_RESERVED = 8'hc1;
	localparam logic [7:0] TB_EXT8     = 8'hc7;
	localparam logic [7:0] TB_FIXEXT1  = 8'hd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int          mismatches;
	int          outstanding;
	int          checked;
	logic [11:0] kinds_seen;

	int          src_idle_pct = 29;
	int          sink_idle_pct = 67;
	int          bytes_sent = 0;
	int          cycle_count = 0;
	logic [7:0]  token_bytes[$];

	msgpack_token_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	msgpack_result_checker u_result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_end      (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_value   (m_axis_tdata),
		.out_kind    (m_axis_tuser),
		.out_last    (m_axis_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.kinds_seen  (kinds_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eod);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eod;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic void push_be(input int nbytes, input logic [63:0] v);
		for (int i = nbytes - 1; i >= 0; i--)
			token_bytes.push_back(v[8 * i +: 8]);
	endfunction

	function automatic logic [63:0] random_field(input int nbytes);
		logic [63:0] v;
		case ($urandom_range(0, 5))
		0: v = '0;
		1: v = '1;
		2: v = 64'd1 << (8 * nbytes - 1);
		default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [31:0] single_pattern();
		logic [31:0] r;
		logic [31:0] f;
		r = $urandom;
		case ($urandom_range(0, 5))
		0: f = {r[31], 8'h00, r[22:0]};
		1: f = {r[31], 8'h00, 23'd1 << $urandom_range(0, 22)};
		2: f = {r[31], 8'hff, 23'd0};
		3: f = {r[31], 8'hff, r[22:0]};
		default: f = r;
		endcase
		return f;
	endfunction

	task automatic send_token();
		int          sel;
		int          code;
		int          nbytes;
		int          cut;
		int          fill;
		logic [31:0] r;
		logic [31:0] len;
		logic [7:0]  hdr;
		bit          force_cut;
		bit          end_here;
		token_bytes.delete();
		force_cut = 1'b0;
		len = '0;
		r = $urandom;
		sel = $urandom_range(0, 14);
		case (sel)
		0: token_bytes.push_back({1'b0, r[6:0]});
		1: token_bytes.push_back({3'b111, r[4:0]});
		2: token_bytes.push_back(r[1:0] == 2'd0 ? TB_NIL : (r[0] ? TB_TRUE : TB_FALSE));
		3: token_bytes.push_back({3'b100, r[4:0]});
		4, 5, 14: begin
			code = $urandom_range(0, 3);
			nbytes = 1 << code;
			hdr = (sel == 4) ? TB_UINT8 : TB_INT8;
			token_bytes.push_back(hdr + 8'(code));
			push_be(nbytes, random_field(nbytes));
		end
		6: begin
			token_bytes.push_back(TB_FLOAT32);
			push_be(4, {32'd0, single_pattern()});
		end
		7: begin
			token_bytes.push_back(TB_FLOAT64);
			push_be(8, random_field(8));
		end
		8: begin
			len = ($urandom_range(3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
			token_bytes.push_back({3'b101, len[4:0]});
		end
		9, 10: begin
			code = $urandom_range(0, 2);
			nbytes = 1 << code;
			hdr = (sel == 9) ? TB_STR8 : TB_BIN8;
			token_bytes.push_back(hdr + 8'(code));
			if ($urandom_range(7) == 0)
				len = (nbytes == 4) ? 32'hffff_ffff : (32'd1 << (8 * nbytes)) - 32'd1;
			else
				len = $urandom_range(0, 5);
			push_be(nbytes, {32'd0, len});
		end
		11: begin
			case (r[1:0])
			2'd0: token_bytes.push_back(TB_ARRAY16);
			2'd1: token_bytes.push_back(TB_ARRAY32);
			2'd2: token_bytes.push_back(TB_MAP16);
			default: token_bytes.push_back(TB_MAP32);
			endcase
			nbytes = r[0] ? 4 : 2;
			push_be(nbytes, random_field(nbytes));
		end
		12: begin
			code = $urandom_range(0, 8);
			if (code == 0)
				token_bytes.push_back(TB_RESERVED);
			else if (code <= 3)
				token_bytes.push_back(TB_EXT8 + 8'(code - 1));
			else
				token_bytes.push_back(TB_FIXEXT1 + 8'(code - 4));
		end
		default: token_bytes.push_back(r[7:0]);
		endcase
		if (sel >= 8 && sel <= 10) begin
			// Long strings are only started: four bytes follow, and the token is cut short.
			force_cut = (len > 32'd40);
			fill = force_cut ? 4 : int'(len);
			for (int i = 0; i < fill; i++) begin
				r = $urandom;
				token_bytes.push_back(r[7:0]);
			end
		end
		if (force_cut || $urandom_range(99) < 6)
			cut = $urandom_range(0, token_bytes.size() - 1);
		else
			cut = token_bytes.size() - 1;
		end_here = force_cut || cut < token_bytes.size() - 1 || $urandom_range(99) < 5;
		for (int i = 0; i <= cut; i++)
			send_byte(token_bytes[i], end_here && i == cut);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(TB_NIL, 1'b0);
		send_byte(TB_FALSE, 1'b0);
		send_byte(TB_TRUE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(TB_POSFIX_MAX, 1'b0);
		send_byte(TB_NEGFIX_MIN, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(TB_FIXARR_MAX, 1'b0);
		send_byte(TB_RESERVED, 1'b0);
		send_byte(8'ha0, 1'b0);
		send_byte(TB_BIN8, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(TB_FLOAT32, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(TB_UINT16, 1'b0);
		send_byte(8'h12, 1'b1);
		send_byte(TB_INT64, 1'b1);
		send_byte(8'ha3, 1'b1);
		send_byte(8'ha2, 1'b0);
		send_byte(8'h41, 1'b1);

		while (bytes_sent < 210)
			send_token();
		wait_drained();
		src_idle_pct = 67;
		sink_idle_pct <= 29;
		while (bytes_sent < 395)
			send_token();
		wait_drained();
		src_idle_pct = 0;
		sink_idle_pct <= 0;
		while (bytes_sent < 580)
			send_token();
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Summary: %0d stream bytes sent under three idling patterns, %0d results checked,",
			bytes_sent, checked);
		$display("Summary: %0d of 12 result kinds observed, %0d mismatches.",
			$countones(kinds_seen), mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mptd_pkg.sv
rtl/msgpack_token_decoder.sv
tb/msgpack_result_checker.sv
tb/tb_top.sv
